[hdl/brou_pkg.sv]
// Package for the binary rule outside-update block.
// Item layouts, mode and config register codes, FPU request/response structs.
// No dependencies.
`default_nettype none

package brou_pkg;

  localparam int CNT_W = 5;
  localparam int IDX_W = 4;
  localparam int DW    = 64;

  localparam logic [2:0] MODE_WEIGHT  = 3'd0;
  localparam logic [2:0] MODE_PARENT  = 3'd1;
  localparam logic [2:0] MODE_LEFT    = 3'd2;
  localparam logic [2:0] MODE_RIGHT   = 3'd3;
  localparam logic [2:0] MODE_COMPUTE = 3'd4;

  localparam logic [1:0] CFG_PARENT = 2'd0;
  localparam logic [1:0] CFG_LEFT   = 2'd1;
  localparam logic [1:0] CFG_RIGHT  = 2'd2;

  localparam logic [DW-1:0] FP_ZERO  = 64'h0000_0000_0000_0000;
  localparam logic [DW-1:0] FP_QNAN  = 64'hFFF8_0000_0000_0000;
  localparam logic [DW-1:0] FP_QBIT  = 64'h0008_0000_0000_0000;

  typedef struct packed {
    logic [2:0]       mode;
    logic [IDX_W-1:0] parent_index;
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    logic [DW-1:0]    score;
    logic             score_null;
    logic [DW-1:0]    outside_start;
    logic             outside_null;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic [DW-1:0]    left_outside;
    logic             left_outside_null;
    logic [DW-1:0]    right_outside;
    logic             right_outside_null;
    logic [DW-1:0]    marginal;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] parent_count;
    logic [CNT_W-1:0] left_count;
    logic [CNT_W-1:0] right_count;
  } cnt_cfg_t;

  typedef struct packed {
    logic          go;
    logic          op_mul;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] res;
  } fpu_rsp_t;

endpackage

`default_nettype wire

[hdl/brou_fpu.sv]
// Iterative IEEE double add / multiply unit, round to nearest even.
// Multiply uses four 27x27 partial products; normalize one bit a cycle.
// Depends on brou_pkg.
`default_nettype none

module brou_fpu import brou_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  fpu_req_t req,
  output fpu_rsp_t rsp
);

  localparam int MW = 110;

  typedef enum logic [2:0] {F_IDLE, F_PRE, F_MUL, F_SUM, F_NORM, F_RND} fstate_t;

  fstate_t state;
  logic              op_mul;
  logic [DW-1:0]     a, b;
  logic [MW-1:0]     m, xm, ym;
  logic              sub, zsign, rs;
  logic signed [13:0] e;
  logic [52:0]       ma, mb;
  logic [1:0]        cnt;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
  logic [10:0] ea, eb, dexp;
  logic [52:0] fa_m, fb_m, xmant, ymant;
  logic [MW-1:0] yfull, yshift, msum, ppw;
  logic [26:0] px, py;
  logic [53:0] pp;
  logic [52:0] mant, mant2;
  logic        g, st, up;
  logic [53:0] mr;
  logic signed [13:0] e2;
  logic [DW-1:0] rbits;

  assign a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
  assign b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  assign a_inf  = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
  assign b_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
  assign a_zero = (a[62:0] == 63'd0);
  assign b_zero = (b[62:0] == 63'd0);
  assign ea     = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
  assign eb     = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
  assign fa_m   = {(a[62:52] != 11'd0), a[51:0]};
  assign fb_m   = {(b[62:52] != 11'd0), b[51:0]};
  assign a_big  = (a[62:0] >= b[62:0]);
  assign xmant  = a_big ? fa_m : fb_m;
  assign ymant  = a_big ? fb_m : fa_m;
  assign dexp   = a_big ? (ea - eb) : (eb - ea);
  assign yfull  = {1'b0, ymant, 56'd0};

  // beyond 56 places the smaller operand only acts as sticky
  always_comb begin
    if (ymant == 53'd0) begin
      yshift = '0;
    end else if (dexp > 11'd56) begin
      yshift = MW'(1);
    end else begin
      yshift = yfull >> dexp;
    end
  end

  assign msum = sub ? (xm - ym) : (xm + ym);

  assign px = cnt[1] ? ma[52:26] : {1'b0, ma[25:0]};
  assign py = cnt[0] ? mb[52:26] : {1'b0, mb[25:0]};
  assign pp = px * py;

  always_comb begin
    case (cnt)
      2'd0:    ppw = MW'(pp) << 4;
      2'd3:    ppw = MW'(pp) << 56;
      default: ppw = MW'(pp) << 30;
    endcase
  end

  assign mant  = m[MW-2 -: 53];
  assign g     = m[55];
  assign st    = |m[54:0];
  assign up    = g & (st | mant[0]);
  assign mr    = {1'b0, mant} + 54'(up);
  assign mant2 = mr[53] ? mr[53:1] : mr[52:0];
  assign e2    = mr[53] ? (e + 14'sd1) : e;

  always_comb begin
    if (e2 >= 14'sd2047) begin
      rbits = {rs, 11'h7FF, 52'd0};
    end else begin
      rbits = {rs, (mant2[52] ? e2[10:0] : 11'd0), mant2[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (req.go) begin
            a      <= req.a;
            b      <= req.b;
            op_mul <= req.op_mul;
            state  <= F_PRE;
          end
        end
        F_PRE: begin
          if (a_nan) begin
            rsp.res <= a | FP_QBIT; rsp.done <= 1'b1; state <= F_IDLE;
          end else if (b_nan) begin
            rsp.res <= b | FP_QBIT; rsp.done <= 1'b1; state <= F_IDLE;
          end else if (op_mul) begin
            if ((a_inf && b_zero) || (b_inf && a_zero)) begin
              rsp.res <= FP_QNAN; rsp.done <= 1'b1; state <= F_IDLE;
            end else if (a_inf || b_inf) begin
              rsp.res  <= {a[63] ^ b[63], 11'h7FF, 52'd0};
              rsp.done <= 1'b1;
              state    <= F_IDLE;
            end else if (a_zero || b_zero) begin
              rsp.res  <= {a[63] ^ b[63], 63'd0};
              rsp.done <= 1'b1;
              state    <= F_IDLE;
            end else begin
              ma    <= fa_m;
              mb    <= fb_m;
              e     <= {3'b000, ea} + {3'b000, eb} - 14'sd1023;
              rs    <= a[63] ^ b[63];
              m     <= '0;
              cnt   <= 2'd0;
              state <= F_MUL;
            end
          end else begin
            if (a_inf && b_inf && (a[63] != b[63])) begin
              rsp.res <= FP_QNAN; rsp.done <= 1'b1; state <= F_IDLE;
            end else if (a_inf) begin
              rsp.res <= a; rsp.done <= 1'b1; state <= F_IDLE;
            end else if (b_inf) begin
              rsp.res <= b; rsp.done <= 1'b1; state <= F_IDLE;
            end else begin
              xm    <= {1'b0, xmant, 56'd0};
              ym    <= yshift;
              e     <= {3'b000, (a_big ? ea : eb)};
              rs    <= a_big ? a[63] : b[63];
              sub   <= a[63] ^ b[63];
              zsign <= a[63] & b[63];
              state <= F_SUM;
            end
          end
        end
        F_MUL: begin
          m   <= m + ppw;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= F_NORM;
          end
        end
        F_SUM: begin
          m <= msum;
          if (msum == '0) begin
            rs    <= zsign;
            state <= F_RND;
          end else begin
            state <= F_NORM;
          end
        end
        F_NORM: begin
          if (m[MW-1]) begin
            m <= {1'b0, m[MW-1:2], m[1] | m[0]};
            e <= e + 14'sd1;
          end else if (e < 14'sd1) begin
            if (e < -14'sd115) begin
              m <= MW'(1);
              e <= 14'sd1;
            end else begin
              m <= {1'b0, m[MW-1:2], m[1] | m[0]};
              e <= e + 14'sd1;
            end
          end else if (!m[MW-2] && (e > 14'sd1)) begin
            m <= {m[MW-2:0], 1'b0};
            e <= e - 14'sd1;
          end else begin
            state <= F_RND;
          end
        end
        F_RND: begin
          rsp.res  <= rbits;
          rsp.done <= 1'b1;
          state    <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/brou_ctrl.sv]
// Sequencer: weight memory, annotation vectors and the i/j/k contraction loop.
// Drives the shared FPU and the result register.
// Depends on brou_pkg.
`default_nettype none

module brou_ctrl import brou_pkg::*; #(
  parameter int MAX_ANNOT = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cnt_cfg_t  cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  output fpu_req_t  fpu_req,
  input  fpu_rsp_t  fpu_rsp
);

  localparam int CL = (MAX_ANNOT < 16) ? MAX_ANNOT : 16;
  localparam int NW = (CL > 1) ? $clog2(CL) : 1;
  localparam int WD = MAX_ANNOT * MAX_ANNOT * MAX_ANNOT;
  localparam int WA = (WD > 1) ? $clog2(WD) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PSEL, S_JST, S_JFR, S_KST, S_KRD, S_KM1, S_KA1,
    S_KM2, S_KA2, S_JEND, S_JM3, S_JA3, S_JM4, S_JA4, S_OUT
  } state_t;

  state_t state;
  logic [CNT_W-1:0] i, j, k, np, nl, nr, nn;
  logic [DW-1:0]    up, fr, w, acc, dl, marg;

  logic [DW-1:0] wmem [WD];
  logic [DW-1:0] wrd;
  logic [DW-1:0] p_val [CL];
  logic          p_null [CL];
  logic [DW-1:0] lin [CL];
  logic          lin_null [CL];
  logic [DW-1:0] lout [CL];
  logic          lout_null [CL];
  logic [DW-1:0] rin [CL];
  logic          rin_null [CL];
  logic [DW-1:0] rout [CL];
  logic          rout_null [CL];

  logic          accept, wr_en;
  logic [WA-1:0] waddr_w, waddr_r;
  logic [NW-1:0] pidx, lidx, ridx;
  logic [NW-1:0] ld_p, ld_l, ld_r;
  logic [DW-1:0] cur_pval, cur_lin, cur_lout, cur_rin, cur_rout;
  logic          cur_pnull, cur_lin_null, cur_lout_null, cur_rin_null, cur_rout_null;
  logic          lout_we, rout_we, ln, rn;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (c > CNT_W'(CL)) begin
      r = CNT_W'(CL);
    end else begin
      r = c;
    end
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign wr_en = accept && (in_item.mode == MODE_WEIGHT) &&
                 (32'(in_item.parent_index) < MAX_ANNOT) &&
                 (32'(in_item.left_index) < MAX_ANNOT) &&
                 (32'(in_item.right_index) < MAX_ANNOT);
  assign waddr_w = WA'((32'(in_item.parent_index) * MAX_ANNOT +
                        32'(in_item.left_index)) * MAX_ANNOT +
                       32'(in_item.right_index));
  assign waddr_r = WA'((32'(i) * MAX_ANNOT + 32'(j)) * MAX_ANNOT + 32'(k));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[waddr_w] <= in_item.score;
    end
    wrd <= wmem[waddr_r];
  end

  assign pidx = i[NW-1:0];
  assign lidx = j[NW-1:0];
  assign ridx = (state == S_OUT) ? j[NW-1:0] : k[NW-1:0];
  assign ld_p = in_item.parent_index[NW-1:0];
  assign ld_l = in_item.left_index[NW-1:0];
  assign ld_r = in_item.right_index[NW-1:0];

  assign cur_pval      = p_val[pidx];
  assign cur_pnull     = p_null[pidx];
  assign cur_lin       = lin[lidx];
  assign cur_lin_null  = lin_null[lidx];
  assign cur_lout      = lout[lidx];
  assign cur_lout_null = lout_null[lidx];
  assign cur_rin       = rin[ridx];
  assign cur_rin_null  = rin_null[ridx];
  assign cur_rout      = rout[ridx];
  assign cur_rout_null = rout_null[ridx];

  assign lout_we = (state == S_JA3) && fpu_rsp.done;
  assign rout_we = (state == S_KA2) && fpu_rsp.done;

  always_ff @(posedge clk) begin
    if (accept && (in_item.mode == MODE_PARENT) &&
        ({1'b0, in_item.parent_index} < CNT_W'(CL))) begin
      p_val[ld_p]  <= in_item.score;
      p_null[ld_p] <= in_item.score_null;
    end
    if (accept && (in_item.mode == MODE_LEFT) &&
        ({1'b0, in_item.left_index} < CNT_W'(CL))) begin
      lin[ld_l]       <= in_item.score;
      lin_null[ld_l]  <= in_item.score_null;
      lout[ld_l]      <= in_item.outside_start;
      lout_null[ld_l] <= in_item.outside_null;
    end else if (lout_we) begin
      lout[lidx] <= fpu_rsp.res;
    end
    if (accept && (in_item.mode == MODE_RIGHT) &&
        ({1'b0, in_item.right_index} < CNT_W'(CL))) begin
      rin[ld_r]       <= in_item.score;
      rin_null[ld_r]  <= in_item.score_null;
      rout[ld_r]      <= in_item.outside_start;
      rout_null[ld_r] <= in_item.outside_null;
    end else if (rout_we) begin
      rout[ridx] <= fpu_rsp.res;
    end
  end

  assign ln = (j >= nl) || cur_lout_null;
  assign rn = (j >= nr) || cur_rout_null;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      fpu_req.go <= 1'b0;
    end else begin
      fpu_req.go <= 1'b0;
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (in_item.mode == MODE_COMPUTE)) begin
            np    <= eff_count(cfg.parent_count);
            nl    <= eff_count(cfg.left_count);
            nr    <= eff_count(cfg.right_count);
            nn    <= (eff_count(cfg.left_count) > eff_count(cfg.right_count)) ?
                     eff_count(cfg.left_count) : eff_count(cfg.right_count);
            marg  <= FP_ZERO;
            i     <= '0;
            state <= S_PSEL;
          end
        end
        S_PSEL: begin
          if (i == np) begin
            j     <= '0;
            state <= S_OUT;
          end else if (cur_pnull || (cur_pval[62:0] == 63'd0)) begin
            i <= i + CNT_W'(1);
          end else begin
            up    <= cur_pval;
            j     <= '0;
            state <= S_JST;
          end
        end
        S_JST: begin
          if (j == nl) begin
            i     <= i + CNT_W'(1);
            state <= S_PSEL;
          end else begin
            acc <= FP_ZERO;
            k   <= '0;
            if (!cur_lin_null) begin
              fpu_req <= '{go: 1'b1, op_mul: 1'b1, a: up, b: cur_lin};
              state   <= S_JFR;
            end else begin
              fr    <= FP_ZERO;
              state <= S_KST;
            end
          end
        end
        S_JFR: begin
          if (fpu_rsp.done) begin
            fr    <= fpu_rsp.res;
            state <= S_KST;
          end
        end
        S_KST: begin
          if (k == nr) begin
            state <= S_JEND;
          end else if (cur_rin_null) begin
            k <= k + CNT_W'(1);
          end else begin
            state <= S_KRD;
          end
        end
        S_KRD: begin
          w       <= wrd;
          fpu_req <= '{go: 1'b1, op_mul: 1'b1, a: cur_rin, b: wrd};
          state   <= S_KM1;
        end
        S_KM1: begin
          if (fpu_rsp.done) begin
            fpu_req <= '{go: 1'b1, op_mul: 1'b0, a: acc, b: fpu_rsp.res};
            state   <= S_KA1;
          end
        end
        S_KA1: begin
          if (fpu_rsp.done) begin
            acc     <= fpu_rsp.res;
            fpu_req <= '{go: 1'b1, op_mul: 1'b1, a: fr, b: w};
            state   <= S_KM2;
          end
        end
        S_KM2: begin
          if (fpu_rsp.done) begin
            fpu_req <= '{go: 1'b1, op_mul: 1'b0, a: cur_rout, b: fpu_rsp.res};
            state   <= S_KA2;
          end
        end
        S_KA2: begin
          if (fpu_rsp.done) begin
            k     <= k + CNT_W'(1);
            state <= S_KST;
          end
        end
        S_JEND: begin
          if (!cur_lout_null) begin
            fpu_req <= '{go: 1'b1, op_mul: 1'b1, a: up, b: acc};
            state   <= S_JM3;
          end else begin
            j     <= j + CNT_W'(1);
            state <= S_JST;
          end
        end
        S_JM3: begin
          if (fpu_rsp.done) begin
            dl      <= fpu_rsp.res;
            fpu_req <= '{go: 1'b1, op_mul: 1'b0, a: cur_lout, b: fpu_rsp.res};
            state   <= S_JA3;
          end
        end
        S_JA3: begin
          if (fpu_rsp.done) begin
            if (!cur_lin_null) begin
              fpu_req <= '{go: 1'b1, op_mul: 1'b1, a: dl, b: cur_lin};
              state   <= S_JM4;
            end else begin
              j     <= j + CNT_W'(1);
              state <= S_JST;
            end
          end
        end
        S_JM4: begin
          if (fpu_rsp.done) begin
            fpu_req <= '{go: 1'b1, op_mul: 1'b0, a: marg, b: fpu_rsp.res};
            state   <= S_JA4;
          end
        end
        S_JA4: begin
          if (fpu_rsp.done) begin
            marg  <= fpu_rsp.res;
            j     <= j + CNT_W'(1);
            state <= S_JST;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid                   <= 1'b1;
            out_item.entry_index        <= j[IDX_W-1:0];
            out_item.left_outside       <= ln ? FP_ZERO : cur_lout;
            out_item.left_outside_null  <= ln;
            out_item.right_outside      <= rn ? FP_ZERO : cur_rout;
            out_item.right_outside_null <= rn;
            out_item.marginal           <= (j + CNT_W'(1) == nn) ? marg : FP_ZERO;
            out_item.last               <= (j + CNT_W'(1) == nn);
            if (j + CNT_W'(1) == nn) begin
              state <= S_IDLE;
            end else begin
              j <= j + CNT_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // one FPU operation in flight at a time
  a_go_pulse: assert property (@(posedge clk) disable iff (rst)
    fpu_req.go |=> !fpu_req.go)
    else $error("FPU issued on consecutive cycles");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    fpu_rsp.done |-> (state == S_JFR || state == S_KM1 || state == S_KA1 ||
                      state == S_KM2 || state == S_KA2 || state == S_JM3 ||
                      state == S_JA3 || state == S_JM4 || state == S_JA4))
    else $error("FPU result outside a wait state");

  a_loop_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_KST) |-> (k <= nr)) and ((state == S_JST) |-> (j <= nl)))
    else $error("loop counter past its count");

endmodule

`default_nettype wire

[hdl/binary_rule_outside_update.sv]
// Binary rule outside-score update, top level: count registers, sequencer, FPU.
// Depends on brou_pkg, brou_fpu, brou_ctrl.
//
// Usage:
//   in_valid/in_ready carry one item. Modes weight, parent, left and right
//   store into the weight memory or the annotation vectors when accepted.
//   A compute item runs the i/j/k contraction and returns max(left, right)
//   items on out_valid/out_ready, entry 0 first, last marked, where a count
//   of 0 acts as 1 and counts cap at min(MAX_ANNOT, 16). Count registers
//   are written through cfg_we/cfg_index/cfg_data while idle. A compute
//   item's run time grows with each i/j/k triple with a non-null right
//   entry and each i/j pair, all set by the single shared iterative
//   double add/multiply unit; an operation with subnormal operands or
//   results, or a cancelling subtraction, takes longer.
//   Results go through an output register: a stalled receiver holds the
//   sequencer in its output phase only; the next input item is taken as
//   soon as the last result is in the register.
//   Reset (rst, synchronous) clears control and sets all counts to 16; the
//   weight memory and vectors hold no defined value until loaded.
`default_nettype none

module binary_rule_outside_update import brou_pkg::*; #(
  parameter int MAX_ANNOT = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  cnt_cfg_t cfg;
  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.parent_count <= CNT_W'(16);
      cfg.left_count   <= CNT_W'(16);
      cfg.right_count  <= CNT_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PARENT: cfg.parent_count <= cfg_data;
        CFG_LEFT:   cfg.left_count   <= cfg_data;
        CFG_RIGHT:  cfg.right_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  brou_ctrl #(
    .MAX_ANNOT(MAX_ANNOT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .fpu_req   (fpu_req),
    .fpu_rsp   (fpu_rsp)
  );

  brou_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (fpu_req),
    .rsp (fpu_rsp)
  );

endmodule

`default_nettype wire

[sim/binary_rule_outside_update_test.sv]
// Self-checking testbench for binary_rule_outside_update: loads random tensors and vectors,
// runs compute items and checks every result item against an in-bench double predictor.
// Depends on brou_pkg and the binary_rule_outside_update RTL.
`timescale 1ns / 1ps

module binary_rule_outside_update_test;
  import brou_pkg::*;

  localparam logic [1:0] CFG_NONE = 2'd3;
  localparam int N = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_PARENT;
  logic [CNT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  binary_rule_outside_update u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [63:0] wt [N*N*N];
  logic [63:0] par_val [N];
  logic        par_null [N];
  logic [63:0] lin_val [N], lout_val [N], rin_val [N], rout_val [N];
  logic        lin_null [N], lout_null [N], rin_null [N], rout_null [N];
  logic [4:0]  cnt_par = 5'd16, cnt_left = 5'd16, cnt_right = 5'd16;

  in_item_t  pending [$];
  out_item_t expected_rows [$];
  int errors = 0;
  int cyc = 0;
  logic in_took = 1'b0;
  logic quiet;

  assign quiet = (cyc % 20000) < 3000;

  function automatic int eff(logic [4:0] c);
    if (c == 0) return 1;
    if (c > N) return N;
    return c;
  endfunction

  function automatic logic is_nan(logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != 0);
  endfunction

  function automatic logic same_dbl(logic [63:0] a, logic [63:0] b);
    return (a == b) || (is_nan(a) && is_nan(b));
  endfunction

  function automatic logic [63:0] rnd_dbl();
    logic [63:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(9))
      0: b = '0;
      1: b = 64'h8000_0000_0000_0000;
      2, 3: ;
      default: b[62:52] = 11'(11'h3F0 + $urandom_range(31));
    endcase
    return b;
  endfunction

  function automatic in_item_t mk(logic [2:0] m, int p, int l, int r);
    in_item_t it;
    it.mode = m;
    it.parent_index = IDX_W'(p);
    it.left_index = IDX_W'(l);
    it.right_index = IDX_W'(r);
    it.score = rnd_dbl();
    it.score_null = ($urandom_range(99) < 15);
    it.outside_start = rnd_dbl();
    it.outside_null = ($urandom_range(99) < 15);
    return it;
  endfunction

  task automatic run_contraction();
    int np, nl, nr, n;
    real up, lin, acc, fr, w, dl, marg;
    out_item_t o;
    np = eff(cnt_par);
    nl = eff(cnt_left);
    nr = eff(cnt_right);
    marg = 0.0;
    for (int i = 0; i < np; i++) begin
      if (par_null[i]) continue;
      up = $bitstoreal(par_val[i]);
      if (up == 0.0) continue;
      for (int j = 0; j < nl; j++) begin
        lin = $bitstoreal(lin_val[j]);
        acc = 0.0;
        fr = 0.0;
        if (!lin_null[j]) fr = up * lin;
        for (int k = 0; k < nr; k++) begin
          if (rin_null[k]) continue;
          w = $bitstoreal(wt[(i*N + j)*N + k]);
          acc = acc + $bitstoreal(rin_val[k]) * w;
          rout_val[k] = $realtobits($bitstoreal(rout_val[k]) + fr * w);
        end
        if (!lout_null[j]) begin
          dl = up * acc;
          lout_val[j] = $realtobits($bitstoreal(lout_val[j]) + dl);
          if (!lin_null[j]) marg = marg + dl * lin;
        end
      end
    end
    n = (nl > nr) ? nl : nr;
    for (int j = 0; j < n; j++) begin
      o.entry_index = IDX_W'(j);
      o.left_outside_null = (j >= nl) || lout_null[j];
      o.left_outside = o.left_outside_null ? 64'd0 : lout_val[j];
      o.right_outside_null = (j >= nr) || rout_null[j];
      o.right_outside = o.right_outside_null ? 64'd0 : rout_val[j];
      o.last = (j + 1 == n);
      o.marginal = o.last ? $realtobits(marg) : 64'd0;
      expected_rows.push_back(o);
    end
  endtask

  task automatic apply_item(in_item_t it);
    case (it.mode)
      MODE_WEIGHT: wt[(it.parent_index*N + it.left_index)*N + it.right_index] = it.score;
      MODE_PARENT: begin
        par_val[it.parent_index] = it.score;
        par_null[it.parent_index] = it.score_null;
      end
      MODE_LEFT: begin
        lin_val[it.left_index] = it.score;
        lin_null[it.left_index] = it.score_null;
        lout_val[it.left_index] = it.outside_start;
        lout_null[it.left_index] = it.outside_null;
      end
      MODE_RIGHT: begin
        rin_val[it.right_index] = it.score;
        rin_null[it.right_index] = it.score_null;
        rout_val[it.right_index] = it.outside_start;
        rout_null[it.right_index] = it.outside_null;
      end
      MODE_COMPUTE: run_contraction();
      default: ;
    endcase
  endtask

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    in_took <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) apply_item(in_item);
    if (!rst && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        report("unexpected item", 64'd0, 64'(out_item.entry_index));
      end else begin
        out_item_t e;
        e = expected_rows.pop_front();
        if (e.entry_index != out_item.entry_index)
          report("entry_index", 64'(e.entry_index), 64'(out_item.entry_index));
        if (e.left_outside_null != out_item.left_outside_null)
          report("left_outside_null", 64'(e.left_outside_null),
                 64'(out_item.left_outside_null));
        if (!same_dbl(e.left_outside, out_item.left_outside))
          report("left_outside", e.left_outside, out_item.left_outside);
        if (e.right_outside_null != out_item.right_outside_null)
          report("right_outside_null", 64'(e.right_outside_null),
                 64'(out_item.right_outside_null));
        if (!same_dbl(e.right_outside, out_item.right_outside))
          report("right_outside", e.right_outside, out_item.right_outside);
        if (!same_dbl(e.marginal, out_item.marginal))
          report("marginal", e.marginal, out_item.marginal);
        if (e.last != out_item.last)
          report("last", 64'(e.last), 64'(out_item.last));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_took) begin
        if (pending.size() != 0 && (quiet || $urandom_range(99) >= 15)) begin
          in_item <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 15);
    end
  end

  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || expected_rows.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_counts(logic [4:0] p, logic [4:0] l, logic [4:0] r);
    wait_idle();
    write_reg(CFG_PARENT, p);
    write_reg(CFG_LEFT, l);
    write_reg(CFG_RIGHT, r);
    cnt_par = p;
    cnt_left = l;
    cnt_right = r;
  endtask

  // every entry a compute reads gets written first
  task automatic load_all();
    int np, nl, nr;
    np = eff(cnt_par);
    nl = eff(cnt_left);
    nr = eff(cnt_right);
    for (int i = 0; i < np; i++)
      for (int j = 0; j < nl; j++)
        for (int k = 0; k < nr; k++) pending.push_back(mk(MODE_WEIGHT, i, j, k));
    for (int i = 0; i < np; i++) pending.push_back(mk(MODE_PARENT, i, 0, 0));
    for (int j = 0; j < nl; j++) pending.push_back(mk(MODE_LEFT, 0, j, 0));
    for (int k = 0; k < nr; k++) pending.push_back(mk(MODE_RIGHT, 0, 0, k));
  endtask

  task automatic push_random(int count);
    int np, nl, nr, sel;
    np = eff(cnt_par);
    nl = eff(cnt_left);
    nr = eff(cnt_right);
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 18) pending.push_back(mk(MODE_COMPUTE, $urandom_range(15),
                                         $urandom_range(15), $urandom_range(15)));
      else if (sel < 23) pending.push_back(mk(3'(3'd5 + $urandom_range(2)),
                                              $urandom_range(15),
                                              $urandom_range(15), $urandom_range(15)));
      else if (sel < 33) pending.push_back(mk(3'($urandom_range(3)), $urandom_range(15),
                                              $urandom_range(15), $urandom_range(15)));
      else pending.push_back(mk(3'($urandom_range(3)), $urandom_range(np - 1),
                                $urandom_range(nl - 1), $urandom_range(nr - 1)));
    end
  endtask

  initial begin
    in_item_t it;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: each skip and null case followed by a compute
    set_counts(5'd3, 5'd2, 5'd4);
    write_reg(CFG_NONE, 5'd1);
    load_all();
    pending.push_back(mk(MODE_COMPUTE, 0, 0, 0));
    it = mk(MODE_PARENT, 0, 0, 0); it.score = 64'd0; it.score_null = 1'b0;
    pending.push_back(it);
    it = mk(MODE_PARENT, 1, 0, 0); it.score = 64'h8000_0000_0000_0000; it.score_null = 1'b0;
    pending.push_back(it);
    it = mk(MODE_PARENT, 2, 0, 0); it.score = 64'h3FF0_0000_0000_0000; it.score_null = 1'b1;
    pending.push_back(it);
    pending.push_back(mk(MODE_COMPUTE, 15, 15, 15));
    it = mk(MODE_PARENT, 2, 0, 0); it.score = 64'hBFF8_0000_0000_0000; it.score_null = 1'b0;
    pending.push_back(it);
    it = mk(MODE_LEFT, 0, 0, 0); it.score_null = 1'b1; it.outside_null = 1'b0;
    pending.push_back(it);
    it = mk(MODE_LEFT, 0, 1, 0); it.score_null = 1'b0; it.outside_null = 1'b1;
    pending.push_back(it);
    it = mk(MODE_RIGHT, 0, 0, 0); it.score_null = 1'b1; it.outside_null = 1'b0;
    pending.push_back(it);
    it = mk(MODE_RIGHT, 0, 0, 1); it.score_null = 1'b0; it.outside_null = 1'b1;
    pending.push_back(it);
    it = mk(MODE_RIGHT, 0, 0, 2); it.score = 64'hFFFF_FFFF_FFFF_FFFF; it.score_null = 1'b0;
    it.outside_start = 64'h7FEF_FFFF_FFFF_FFFF; it.outside_null = 1'b0; pending.push_back(it);
    pending.push_back(mk(MODE_COMPUTE, 0, 0, 0));
    pending.push_back(mk(3'd5, 0, 0, 0));
    pending.push_back(mk(3'd7, 15, 15, 15));
    pending.push_back(mk(MODE_WEIGHT, 15, 15, 15));
    pending.push_back(mk(MODE_COMPUTE, 0, 0, 0));

    // large counts saturate; every parent null or zero, so no weight is read
    set_counts(5'd31, 5'd31, 5'd16);
    for (int i = 0; i < N; i++) begin
      it = mk(MODE_PARENT, i, 0, 0);
      if (i % 2 == 0) begin
        it.score_null = 1'b1;
      end else begin
        it.score = (i % 4 == 1) ? 64'd0 : 64'h8000_0000_0000_0000;
        it.score_null = 1'b0;
      end
      pending.push_back(it);
    end
    for (int j = 0; j < N; j++) pending.push_back(mk(MODE_LEFT, 0, j, 0));
    for (int k = 0; k < N; k++) pending.push_back(mk(MODE_RIGHT, 0, 0, k));
    pending.push_back(mk(MODE_COMPUTE, 0, 0, 0));

    // zero counts act as one
    set_counts(5'd0, 5'd0, 5'd0);
    load_all();
    push_random(15);
    pending.push_back(mk(MODE_COMPUTE, 0, 0, 0));

    set_counts(5'($urandom_range(1, 3)), 5'($urandom_range(1, 3)), 5'($urandom_range(1, 3)));
    load_all();
    push_random(12);
    pending.push_back(mk(MODE_COMPUTE, 0, 0, 0));

    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
